FILE: rtl/core/fatcba_pkg.sv
// shared types and constants of the allocation table block chain allocator
package fatcba_pkg;

  localparam int FAT_MAX_BLOCKS = 4096;
  localparam int FAT_HW_LIMIT   = 4096;
  localparam int VAL_W          = 13;
  localparam int TBL_W          = 12;

  localparam logic [VAL_W-1:0] END_MARK  = 13'h1FFE;
  localparam logic [VAL_W-1:0] FAIL_VAL  = 13'h1FFF;
  localparam logic [VAL_W-1:0] SAT_MAX   = 13'h1FFF;
  localparam logic [VAL_W-1:0] VOL_RESET = 13'd4096;
  localparam logic [TBL_W-1:0] TBL_RESET = 12'd64;

  // configuration register indexes
  localparam logic CFG_VOLUME = 1'b0;
  localparam logic CFG_TABLE  = 1'b1;

  typedef enum logic [2:0] {
    ACT_FORMAT = 3'd0,
    ACT_ROOT   = 3'd1,
    ACT_ALLOC  = 3'd2,
    ACT_FREE   = 3'd3,
    ACT_FIND   = 3'd4,
    ACT_APPEND = 3'd5,
    ACT_NEXT   = 3'd6,
    ACT_BAD    = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMT,
    S_ROOT,
    S_SCAN_RD,
    S_SCAN_EV,
    S_ALLOC_RD,
    S_ALLOC_EV,
    S_ALLOC_END,
    S_LINK,
    S_WALK_RD,
    S_WALK_EV,
    S_FREE_RD,
    S_FREE_EV,
    S_NEXT_RD,
    S_NEXT_EV
  } state_t;

  // access bundle for the table memories
  typedef struct packed {
    logic [VAL_W-1:0] used_addr;
    logic             used_we;
    logic             used_wd;
    logic [VAL_W-1:0] link_addr;
    logic             link_we;
    logic [VAL_W-1:0] link_wd;
  } tbl_req_t;

endpackage

FILE: rtl/core/fatcba_tbl.sv
// used bit and next link memories, one access per memory per cycle
module fatcba_tbl
  import fatcba_pkg::*;
#(
  parameter int DEPTH = FAT_MAX_BLOCKS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  tbl_req_t         req,
  output logic             used_rd,
  output logic [VAL_W-1:0] link_rd
);

  logic             used_mem [DEPTH];
  logic [VAL_W-1:0] link_mem [DEPTH];

  // used bit array
  always_ff @(posedge clk) begin
    if (req.used_we) begin
      used_mem[req.used_addr[AW-1:0]] <= req.used_wd;
    end
    used_rd <= used_mem[req.used_addr[AW-1:0]];
  end

  // next link array
  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_addr[AW-1:0]] <= req.link_wd;
    end
    link_rd <= link_mem[req.link_addr[AW-1:0]];
  end

endmodule

FILE: rtl/core/fat_chain_block_allocator.sv
// top level of the allocation table block chain allocator
//
// Command channel: a transaction is taken when start is high and busy is low;
// in_action selects format, allocate root, allocate, free chain, find end,
// append or next. busy stays high until the result has been produced.
// Result channel: out_valid is high for one cycle with out_value and
// out_status; the receiver cannot stall, so the result is always taken.
// Configuration: cfg_we writes volume_blocks (index 0) or table_blocks (index 1)
// from cfg_data; the user must write only while the block is idle (unchecked).
// Work per command, with n the effective volume size and one memory access per step:
//   rejected commands and unknown actions: answered straight from idle
//   format: writes blocks 1 to n-1, allocate root: writes count blocks
//   next: one link read
//   find end: a read and an evaluate step per chain link
//   free: two chain walks, the second clearing the used bits
//   allocate: two scans from the free start, a read and an evaluate step per
//     block visited; append adds a chain walk first
// One command is in work at a time; the table memories with their single
// access port per cycle set the pace.
// Reset clears the free start and free count and restores the register
// defaults; the table contents are undefined until a format.
module fat_chain_block_allocator
  import fatcba_pkg::*;
#(
  parameter int MAX_BLOCKS = FAT_MAX_BLOCKS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_action,
  input  logic [VAL_W-1:0]        in_count,
  input  logic signed [VAL_W-1:0] in_start_block,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_status,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [VAL_W-1:0]        cfg_data
);

  localparam int Depth = (MAX_BLOCKS < FAT_HW_LIMIT) ? MAX_BLOCKS : FAT_HW_LIMIT;
  localparam int Aw    = $clog2(Depth);
  localparam logic [VAL_W-1:0] DepthV = VAL_W'(Depth);

  state_t           state_r, state_nxt;
  action_t          op_r, op_nxt;
  logic [VAL_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0] start_r, start_nxt;
  logic [VAL_W-1:0] cur_r, cur_nxt;
  logic [VAL_W-1:0] steps_r, steps_nxt;
  logic [VAL_W-1:0] found_r, found_nxt;
  logic [VAL_W-1:0] last_r, last_nxt;
  logic [VAL_W-1:0] first_r, first_nxt;
  logic [VAL_W-1:0] prev_r, prev_nxt;
  logic [VAL_W-1:0] free_start_r, free_start_nxt;
  logic [VAL_W-1:0] free_left_r, free_left_nxt;
  logic [VAL_W-1:0] vol_r;
  logic [TBL_W-1:0] tbl_r;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             out_status_r, out_status_nxt;

  tbl_req_t         req;
  logic             used_rd;
  logic [VAL_W-1:0] link_rd;

  // shared conditions
  logic [VAL_W-1:0] n_w;
  logic [VAL_W:0]   tbl_end;
  logic [VAL_W-1:0] fs_w;
  logic [VAL_W-1:0] root_end;
  logic [VAL_W-1:0] cur_inc;
  logic [VAL_W:0]   fl_sum;
  logic             fmt_ok, root_ok, alloc_in_ok, alloc_r_ok;
  logic             walk_bad, scan_stop;

  assign n_w         = (vol_r < DepthV) ? vol_r : DepthV;
  assign tbl_end     = {2'b00, tbl_r} + 14'd1;
  assign fs_w        = tbl_end[VAL_W-1:0];
  assign fmt_ok      = tbl_end < {1'b0, n_w};
  assign root_ok     = (in_count != '0) && (free_start_r < n_w) &&
                       (in_count <= n_w - free_start_r);
  assign alloc_in_ok = (in_count != '0) && (in_count <= free_left_r);
  assign alloc_r_ok  = (cnt_r != '0) && (cnt_r <= free_left_r);
  assign root_end    = free_start_r + cnt_r;
  assign cur_inc     = cur_r + 13'd1;
  assign walk_bad    = (cur_r >= n_w) || (steps_r >= n_w);
  assign scan_stop   = (cur_r >= n_w) || (found_r >= cnt_r);
  assign fl_sum      = {1'b0, free_left_r} + {1'b0, steps_r};

  fatcba_tbl #(.DEPTH(Depth), .AW(Aw)) u_tbl (
    .clk     (clk),
    .req     (req),
    .used_rd (used_rd),
    .link_rd (link_rd)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (action_t'(in_action))
            ACT_FORMAT: state_nxt = fmt_ok ? S_FMT : S_IDLE;
            ACT_ROOT:   state_nxt = root_ok ? S_ROOT : S_IDLE;
            ACT_ALLOC:  state_nxt = alloc_in_ok ? S_SCAN_RD : S_IDLE;
            ACT_FREE:   state_nxt = S_WALK_RD;
            ACT_FIND,
            ACT_APPEND: state_nxt = in_start_block[VAL_W-1] ? S_IDLE : S_WALK_RD;
            ACT_NEXT:   state_nxt = (in_start_block < n_w) ? S_NEXT_RD : S_IDLE;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_FMT:  state_nxt = (cur_inc == n_w) ? S_IDLE : S_FMT;
      S_ROOT: state_nxt = (cur_inc == root_end) ? S_IDLE : S_ROOT;
      S_WALK_RD: begin
        if (cur_r == END_MARK) begin
          case (op_r)
            ACT_FREE:   state_nxt = (steps_r == '0) ? S_IDLE : S_FREE_RD;
            ACT_APPEND: state_nxt = alloc_r_ok ? S_SCAN_RD : S_IDLE;
            default:    state_nxt = S_IDLE;
          endcase
        end else if (walk_bad) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WALK_EV;
        end
      end
      S_WALK_EV: state_nxt = S_WALK_RD;
      S_FREE_RD: state_nxt = (found_r == steps_r) ? S_IDLE : S_FREE_EV;
      S_FREE_EV: state_nxt = S_FREE_RD;
      S_SCAN_RD: begin
        if (scan_stop) begin
          state_nxt = (found_r < cnt_r) ? S_IDLE : S_ALLOC_RD;
        end else begin
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV:   state_nxt = S_SCAN_RD;
      S_ALLOC_RD:  state_nxt = (found_r >= cnt_r) ? S_ALLOC_END : S_ALLOC_EV;
      S_ALLOC_EV:  state_nxt = S_ALLOC_RD;
      S_ALLOC_END: state_nxt = (op_r == ACT_APPEND) ? S_LINK : S_IDLE;
      S_LINK:      state_nxt = S_IDLE;
      S_NEXT_RD:   state_nxt = S_NEXT_EV;
      S_NEXT_EV:   state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory accesses and result
  always_comb begin
    op_nxt         = op_r;
    cnt_nxt        = cnt_r;
    start_nxt      = start_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    found_nxt      = found_r;
    last_nxt       = last_r;
    first_nxt      = first_r;
    prev_nxt       = prev_r;
    free_start_nxt = free_start_r;
    free_left_nxt  = free_left_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    req.used_addr  = cur_r;
    req.used_we    = 1'b0;
    req.used_wd    = 1'b0;
    req.link_addr  = cur_r;
    req.link_we    = 1'b0;
    req.link_wd    = END_MARK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = action_t'(in_action);
          cnt_nxt   = in_count;
          start_nxt = in_start_block;
          steps_nxt = '0;
          found_nxt = '0;
          last_nxt  = END_MARK;
          out_value_nxt  = FAIL_VAL;
          out_status_nxt = 1'b1;
          case (action_t'(in_action))
            ACT_FORMAT: begin
              cur_nxt       = 13'd1;
              out_valid_nxt = !fmt_ok;
            end
            ACT_ROOT: begin
              cur_nxt       = free_start_r;
              out_valid_nxt = !root_ok;
            end
            ACT_ALLOC: begin
              cur_nxt       = free_start_r;
              out_valid_nxt = !alloc_in_ok;
            end
            ACT_FREE: cur_nxt = in_start_block;
            ACT_FIND,
            ACT_APPEND: begin
              cur_nxt       = in_start_block;
              out_valid_nxt = in_start_block[VAL_W-1];
            end
            ACT_NEXT: out_valid_nxt = !(in_start_block < n_w);
            default:  out_valid_nxt = 1'b1;
          endcase
        end
      end
      // format sweep over blocks 1 .. n-1
      S_FMT: begin
        req.used_we = 1'b1;
        req.used_wd = cur_r < fs_w;
        req.link_we = 1'b1;
        req.link_wd = (cur_inc < n_w) ? cur_inc : END_MARK;
        cur_nxt     = cur_inc;
        if (cur_inc == n_w) begin
          free_start_nxt = fs_w;
          free_left_nxt  = '0;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = 1'b0;
        end
      end
      // contiguous run at the free start
      S_ROOT: begin
        req.used_we = 1'b1;
        req.used_wd = 1'b1;
        cur_nxt     = cur_inc;
        if (cur_inc == root_end) begin
          req.link_we    = 1'b1;
          free_start_nxt = root_end;
          free_left_nxt  = n_w - root_end;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = free_start_r;
          out_status_nxt = 1'b0;
        end
      end
      // chain walk: validate and find last block and length
      S_WALK_RD: begin
        if (cur_r == END_MARK) begin
          case (op_r)
            ACT_FREE: begin
              cur_nxt   = start_r;
              found_nxt = '0;
              if (steps_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = 1'b0;
              end
            end
            ACT_APPEND: begin
              cur_nxt       = free_start_r;
              found_nxt     = '0;
              out_valid_nxt = !alloc_r_ok;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = last_r;
              out_status_nxt = 1'b0;
            end
          endcase
        end else if (walk_bad) begin
          out_valid_nxt = 1'b1;
        end else begin
          last_nxt  = cur_r;
          steps_nxt = steps_r + 13'd1;
        end
      end
      S_WALK_EV: cur_nxt = link_rd;
      // second walk clears used bits
      S_FREE_RD: begin
        if (found_r == steps_r) begin
          free_left_nxt  = fl_sum[VAL_W] ? SAT_MAX : fl_sum[VAL_W-1:0];
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = 1'b0;
        end else begin
          req.used_we = 1'b1;
          req.used_wd = 1'b0;
          found_nxt   = found_r + 13'd1;
        end
      end
      S_FREE_EV: cur_nxt = link_rd;
      // first scan counts free blocks
      S_SCAN_RD: begin
        if (scan_stop) begin
          cur_nxt       = free_start_r;
          found_nxt     = '0;
          out_valid_nxt = found_r < cnt_r;
        end
      end
      S_SCAN_EV: begin
        if (!used_rd) begin
          found_nxt = found_r + 13'd1;
        end
        cur_nxt = cur_inc;
      end
      // second scan takes and chains free blocks
      S_ALLOC_RD: ;
      S_ALLOC_EV: begin
        cur_nxt = cur_inc;
        if (!used_rd) begin
          if (found_r == '0) begin
            first_nxt = cur_r;
          end else begin
            req.link_addr = prev_r;
            req.link_we   = 1'b1;
            req.link_wd   = cur_r;
          end
          req.used_we = 1'b1;
          req.used_wd = 1'b1;
          prev_nxt    = cur_r;
          found_nxt   = found_r + 13'd1;
        end
      end
      S_ALLOC_END: begin
        req.link_addr = prev_r;
        req.link_we   = 1'b1;
        free_left_nxt = free_left_r - cnt_r;
        if (op_r != ACT_APPEND) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = first_r;
          out_status_nxt = 1'b0;
        end
      end
      // hook the new chain behind the old one
      S_LINK: begin
        req.link_addr  = last_r;
        req.link_we    = 1'b1;
        req.link_wd    = first_r;
        out_valid_nxt  = 1'b1;
        out_value_nxt  = first_r;
        out_status_nxt = 1'b0;
      end
      S_NEXT_RD: req.link_addr = start_r;
      S_NEXT_EV: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = link_rd;
        out_status_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_start_r <= '0;
      free_left_r  <= '0;
      out_valid_r  <= 1'b0;
      vol_r        <= VOL_RESET;
      tbl_r        <= TBL_RESET;
    end else begin
      state_r      <= state_nxt;
      free_start_r <= free_start_nxt;
      free_left_r  <= free_left_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_VOLUME: vol_r <= cfg_data;
          CFG_TABLE:  tbl_r <= cfg_data[TBL_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    cnt_r        <= cnt_nxt;
    start_r      <= start_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    found_r      <= found_nxt;
    last_r       <= last_nxt;
    first_r      <= first_nxt;
    prev_r       <= prev_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

FILE: tb/sv/fat_chain_block_allocator_tb.sv
// testbench for the allocation table block chain allocator, checked against its own table model
module fat_chain_block_allocator_tb;
  import fatcba_pkg::*;

  localparam int TBL_DEPTH = 4096;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             status;
  } alloc_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [2:0]              in_action;
  logic [VAL_W-1:0]        in_count;
  logic signed [VAL_W-1:0] in_start_block;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_status;
  logic                    cfg_we;
  logic                    cfg_index;
  logic [VAL_W-1:0]        cfg_data;

  // model copy of the table and registers
  logic             blk_used [TBL_DEPTH];
  logic [VAL_W-1:0] blk_link [TBL_DEPTH];
  int               free_first;
  int               free_count;
  int               vol_reg;
  int               tbl_reg;
  int               chain_heads[$];
  alloc_result_t    pending_results[$];
  bit               failed;
  int               burst_left;

  fat_chain_block_allocator DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_count      (in_count),
    .in_start_block(in_start_block),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // overall time limit
  initial begin
    #40000000;
    $display("fat_chain_block_allocator: mismatch");
    $finish;
  end

  function automatic int volume_size();
    int n;
    n = vol_reg;
    if (n > FAT_MAX_BLOCKS) n = FAT_MAX_BLOCKS;
    if (n > FAT_HW_LIMIT) n = FAT_HW_LIMIT;
    return n;
  endfunction

  // follow a chain to the end mark; fails on a bad link or a loop
  function automatic bit walk_chain(int s, output int last, output int len);
    int n;
    int c;
    int steps;
    n = volume_size();
    c = s;
    steps = 0;
    last = END_MARK;
    len = 0;
    while (c != END_MARK) begin
      if (c >= n || steps >= n) return 1'b0;
      last = c;
      steps++;
      c = blk_link[c];
    end
    len = steps;
    return 1'b1;
  endfunction

  // scan from the free start and chain free blocks
  function automatic bit take_chain(int cnt, output int first);
    int n;
    int found;
    int prev;
    n = volume_size();
    found = 0;
    prev = 0;
    first = 0;
    if (cnt == 0 || cnt > free_count) return 1'b0;
    for (int i = free_first; i < n && found < cnt; i++)
      if (!blk_used[i]) found++;
    if (found < cnt) return 1'b0;
    found = 0;
    for (int i = free_first; i < n && found < cnt; i++) begin
      if (blk_used[i]) continue;
      if (found == 0) first = i;
      else blk_link[prev] = i;
      blk_used[i] = 1'b1;
      prev = i;
      found++;
    end
    blk_link[prev] = END_MARK;
    free_count -= cnt;
    return 1'b1;
  endfunction

  // work out the result of one command and update the model table
  function automatic alloc_result_t allocate_result(action_t act, int cnt, int sb);
    alloc_result_t r;
    int n;
    int last;
    int len;
    int first;
    int c;
    int fs;
    bit ok;
    n = volume_size();
    ok = 1'b0;
    r.value = FAIL_VAL;
    case (act)
      ACT_FORMAT: begin
        if (tbl_reg + 1 < n) begin
          fs = tbl_reg + 1;
          for (int i = 1; i < fs; i++) blk_used[i] = 1'b1;
          for (int i = 1; i + 1 < n; i++) blk_link[i] = i + 1;
          blk_link[n-1] = END_MARK;
          for (int i = fs; i < n; i++) blk_used[i] = 1'b0;
          free_first = fs;
          free_count = 0;
          chain_heads.delete();
          r.value = '0;
          ok = 1'b1;
        end
      end
      ACT_ROOT: begin
        if (cnt != 0 && free_first < n && cnt <= n - free_first) begin
          for (int i = 0; i < cnt; i++) blk_used[free_first + i] = 1'b1;
          blk_link[free_first + cnt - 1] = END_MARK;
          r.value = free_first;
          free_first += cnt;
          free_count = n - free_first;
          ok = 1'b1;
        end
      end
      ACT_ALLOC: begin
        if (take_chain(cnt, first)) begin
          r.value = first;
          ok = 1'b1;
        end
      end
      ACT_FREE: begin
        if (walk_chain(sb, last, len)) begin
          c = sb;
          for (int i = 0; i < len; i++) begin
            blk_used[c] = 1'b0;
            c = blk_link[c];
          end
          free_count += len;
          if (free_count > SAT_MAX) free_count = SAT_MAX;
          r.value = '0;
          ok = 1'b1;
        end
      end
      ACT_FIND: begin
        if (sb < 'h1000 && walk_chain(sb, last, len)) begin
          r.value = last;
          ok = 1'b1;
        end
      end
      ACT_APPEND: begin
        if (sb < 'h1000 && walk_chain(sb, last, len) && take_chain(cnt, first)) begin
          blk_link[last] = first;
          r.value = first;
          ok = 1'b1;
        end
      end
      ACT_NEXT: begin
        if (sb < n) begin
          r.value = blk_link[sb];
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (!ok) r.value = FAIL_VAL;
    if (ok && (act == ACT_ROOT || act == ACT_ALLOC || act == ACT_APPEND))
      chain_heads.push_back(r.value);
    r.status = !ok;
    return r;
  endfunction

  // send one command transaction, in bursts with random gaps
  task automatic send_cmd(action_t act, int cnt, int sb);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 25 : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start          <= 1'b1;
    in_action      <= act;
    in_count       <= cnt[VAL_W-1:0];
    in_start_block <= sb[VAL_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(allocate_result(act, cnt, sb & 'h1FFF));
  endtask

  // let the block drain, then write one register
  task automatic write_reg(logic idx, int data);
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[VAL_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_VOLUME) vol_reg = data & 'h1FFF;
    else tbl_reg = data & 'hFFF;
    burst_left = 0;
  endtask

  // result checker
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value %0d status %0d", $time, out_value, out_status);
        failed = 1'b1;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_value !== exp_r.value) begin
          $display("%0t: value expected %0h actual %0h", $time, exp_r.value, out_value);
          failed = 1'b1;
        end
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0b actual %0b", $time, exp_r.status, out_status);
          failed = 1'b1;
        end
      end
    end
  end

  // register defaults, basic reads and the unknown action
  task automatic test_defaults();
    send_cmd(ACT_FORMAT, 0, -2);
    send_cmd(ACT_NEXT, 0, 1);
    send_cmd(ACT_NEXT, 0, 4095);
    send_cmd(ACT_NEXT, 0, -2);
    send_cmd(ACT_BAD, 4096, 4095);
    send_cmd(ACT_ROOT, 0, -2);
    send_cmd(ACT_ALLOC, 0, -2);
  endtask

  // smallest volumes, format that does not fit, short allocations
  task automatic test_small_volume();
    write_reg(CFG_VOLUME, 2);
    write_reg(CFG_TABLE, 1);
    send_cmd(ACT_FORMAT, 0, -2);
    write_reg(CFG_VOLUME, 3);
    send_cmd(ACT_FORMAT, 0, -2);
    send_cmd(ACT_ALLOC, 1, -2);
    send_cmd(ACT_ROOT, 1, -2);
    send_cmd(ACT_ROOT, 1, -2);
    send_cmd(ACT_FIND, 0, 2);
    send_cmd(ACT_FREE, 0, 2);
    send_cmd(ACT_FREE, 0, -2);
    send_cmd(ACT_ALLOC, 1, -2);
    send_cmd(ACT_APPEND, 1, 2);
    send_cmd(ACT_FIND, 0, -1);
    send_cmd(ACT_APPEND, 1, -2);
    send_cmd(ACT_NEXT, 0, 3);
  endtask

  // full volume, long chains and a repeated free that pushes the free count past the volume size
  task automatic test_full_volume();
    write_reg(CFG_VOLUME, 4096);
    send_cmd(ACT_FORMAT, 0, -2);
    send_cmd(ACT_ROOT, 10, -2);
    send_cmd(ACT_ALLOC, 5, -2);
    send_cmd(ACT_APPEND, 3, 2);
    send_cmd(ACT_FIND, 0, 2);
    send_cmd(ACT_FREE, 0, 1);
    send_cmd(ACT_FREE, 0, 1);
    send_cmd(ACT_ALLOC, 4096, -2);
    send_cmd(ACT_ROOT, 4096, -2);
    write_reg(CFG_TABLE, 4095);
    send_cmd(ACT_FORMAT, 0, -2);
    write_reg(CFG_TABLE, 4094);
    send_cmd(ACT_FORMAT, 0, -2);
    send_cmd(ACT_ROOT, 1, -2);
    send_cmd(ACT_ROOT, 1, -2);
  endtask

  // random commands over several volume and table sizes
  task automatic test_random_chains();
    int n;
    int act;
    int cnt;
    int sb;
    int pick;
    for (int phase = 0; phase < 7; phase++) begin
      n = (phase == 6) ? 4096 : $urandom_range(3, 200);
      write_reg(CFG_VOLUME, n);
      write_reg(CFG_TABLE, (phase == 6) ? $urandom_range(1, 64) : $urandom_range(1, n - 2));
      send_cmd(ACT_FORMAT, 0, -2);
      for (int k = 0; k < 14; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) act = ACT_ROOT;
        else if (pick < 40) act = ACT_ALLOC;
        else if (pick < 55) act = ACT_APPEND;
        else if (pick < 70) act = ACT_FREE;
        else if (pick < 80) act = ACT_FIND;
        else if (pick < 90) act = ACT_NEXT;
        else if (pick < 95) act = ACT_FORMAT;
        else act = ACT_BAD;
        pick = $urandom_range(0, 9);
        if (pick < 6) cnt = $urandom_range(1, 4);
        else if (pick < 8) cnt = $urandom_range(1, n);
        else if (pick < 9) cnt = 0;
        else cnt = 4096;
        // never query block 0, which format leaves unwritten
        pick = $urandom_range(0, 9);
        if (pick < 7 && chain_heads.size() > 0)
          sb = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
        else if (pick < 8) sb = -2;
        else if (pick < 9) sb = ($urandom_range(0, 1) == 0) ? -1 : 4095;
        else sb = $urandom_range(1, n + 2);
        send_cmd(action_t'(act), cnt, sb);
      end
    end
  endtask

  // test sequence
  initial begin
    failed         = 1'b0;
    burst_left     = 0;
    free_first     = 0;
    free_count     = 0;
    vol_reg        = VOL_RESET;
    tbl_reg        = TBL_RESET;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_action      <= ACT_FORMAT;
    in_count       <= '0;
    in_start_block <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_VOLUME;
    cfg_data       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_small_volume();
    test_full_volume();
    test_random_chains();
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("fat_chain_block_allocator: match");
    end else begin
      $display("fat_chain_block_allocator: mismatch");
    end
    $finish;
  end

endmodule
